### design/tcsb_pkg.sv
// Shared types and constants for the text console scroll buffer.
// Depends on nothing; the remainder unit, the top level and the bench import it.
`timescale 1ns / 1ps

package tcsb_pkg;

	// Store geometry: each line has COLS character cells plus a terminator cell
	localparam int ROWS   = 16;
	localparam int COLS   = 63;
	localparam int STRIDE = COLS + 1;
	localparam int CELLS  = ROWS * STRIDE;
	localparam int ADDR_W = $clog2(CELLS);

	// Cursor widths: the column spans 0..COLS, the row spans 0..ROWS
	localparam int COL_W = $clog2(STRIDE);
	localparam int ROW_W = $clog2(ROWS + 1);

	// Modulo reduction unit widths
	localparam int MAG_W = 16;
	localparam int DIV_W = 8;

	// Character codes
	localparam logic [7:0] CH_NUL        = 8'h00;
	localparam logic [7:0] CH_NEWLINE    = 8'h0A;
	localparam logic [7:0] CH_SPACE      = 8'h20;
	localparam logic [7:0] CH_LAST_PRINT = 8'h7E;

	typedef enum logic [1:0] {
		OP_PUT  = 2'd0,
		OP_TERM = 2'd1,
		OP_MOVE = 2'd2,
		OP_READ = 2'd3
	} op_t;

	typedef struct packed {
		op_t                operation;
		logic [7:0]         char_code;
		logic signed [15:0] target_col;
		logic signed [15:0] target_row;
		logic [3:0]         read_row;
		logic [5:0]         read_col;
	} req_t;

	typedef struct packed {
		logic [7:0] cell_char;
		logic [5:0] cursor_col;
		logic [4:0] cursor_row;
		logic       scrolled;
	} rsp_t;

endpackage

### design/tcsb_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
`timescale 1ns / 1ps

module tcsb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### design/tcsb_modred.sv
// Remainder unit for cursor moves: reduces the column and row magnitudes by COLS and ROWS.
// Reciprocal multiplication over two register stages; depends on tcsb_pkg.
`timescale 1ns / 1ps

module tcsb_modred
	import tcsb_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [MAG_W-1:0] col_mag,
	input  logic [MAG_W-1:0] row_mag,
	output logic [MAG_W-1:0] col_rem,
	output logic [MAG_W-1:0] row_rem,
	output logic             done
);

	// floor(x * ceil(2^REC_SH / d) / 2^REC_SH) equals floor(x / d) for x < 2^MAG_W, d < 2^DIV_W
	localparam int REC_SH  = MAG_W + DIV_W;
	localparam int PROD_W  = MAG_W + REC_SH;
	localparam int COL_REC = ((1 << REC_SH) + COLS - 1) / COLS;
	localparam int ROW_REC = ((1 << REC_SH) + ROWS - 1) / ROWS;

	logic [PROD_W-1:0] col_prod;
	logic [PROD_W-1:0] row_prod;
	logic              valid_s1;
	logic [MAG_W-1:0]  col_mag_s1;
	logic [MAG_W-1:0]  row_mag_s1;
	logic [MAG_W-1:0]  col_quo_s1;
	logic [MAG_W-1:0]  row_quo_s1;
	logic              done_s2;
	logic [MAG_W-1:0]  col_rem_s2;
	logic [MAG_W-1:0]  row_rem_s2;

	// quotient estimate by constant reciprocals
	assign col_prod = PROD_W'(col_mag) * PROD_W'(COL_REC);
	assign row_prod = PROD_W'(row_mag) * PROD_W'(ROW_REC);

	// stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_s2  <= 1'b0;
		end else begin
			valid_s1 <= start;
			done_s2  <= valid_s1;
		end
	end

	// stage 1 holds the quotients, stage 2 the remainders
	always_ff @(posedge clk) begin
		if (start) begin
			col_mag_s1 <= col_mag;
			row_mag_s1 <= row_mag;
			col_quo_s1 <= col_prod[PROD_W-1:REC_SH];
			row_quo_s1 <= row_prod[PROD_W-1:REC_SH];
		end
		if (valid_s1) begin
			col_rem_s2 <= col_mag_s1 - col_quo_s1 * MAG_W'(COLS);
			row_rem_s2 <= row_mag_s1 - row_quo_s1 * MAG_W'(ROWS);
		end
	end

	assign col_rem = col_rem_s2;
	assign row_rem = row_rem_s2;
	assign done    = done_s2;

endmodule

### design/text_console_scroll_buffer.sv
// Top level of the text console scroll buffer: control sequencer around the cell RAM.
// Depends on tcsb_pkg, tcsb_ram and tcsb_modred.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------
//  req     | in        | req_valid/req_ready  | req_t: operation and operands
//  rsp     | out       | rsp_valid/rsp_ready  | rsp_t: cell, cursor, scrolled
//
// After reset the store is swept to zero, one cell a cycle over all CELLS = 1024 cells,
// with req_ready low. One beat is in work at a time: put and terminate pass
// through ST_EXEC and ST_RESP, a wrapping put also through ST_PUT_TERM, a read
// through ST_READ and a move through ST_MOVE (the two-stage remainder unit). A put
// that scrolls first runs the copy and blank sweeps (ST_SCROLL_CP, ST_SCROLL_DRAIN,
// ST_SCROLL_FILL) through the single RAM port pair, then a second execute pass.
// A stalled result sits in the rsp register while the next beat is accepted.
`timescale 1ns / 1ps

module text_console_scroll_buffer
	import tcsb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_PUT_TERM,
		ST_SCROLL_CP,
		ST_SCROLL_DRAIN,
		ST_SCROLL_FILL,
		ST_MOVE,
		ST_READ,
		ST_RESP
	} state_t;

	state_t            state_q;
	req_t              item_q;
	logic [COL_W-1:0]  cur_col_q;
	logic [ROW_W-1:0]  cur_row_q;
	logic              scrolled_q;
	logic [7:0]        cell_q;
	logic [ADDR_W-1:0] clr_q;
	logic [ROW_W-1:0]  sc_row_q;
	logic [COL_W-1:0]  sc_col_q;
	logic              rd_inrange_q;
	logic              cp_valid_s1;
	logic [ADDR_W-1:0] cp_addr_s1;
	logic              cp_term_s1;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [7:0]        ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [7:0]        ram_rdata;
	logic              mod_start;
	logic [MAG_W-1:0]  col_rem;
	logic [MAG_W-1:0]  row_rem;
	logic              mod_done;
	logic              row_live;
	logic [7:0]        put_char;
	logic              rsp_load;

	function automatic logic [ADDR_W-1:0] cell_addr(
		input logic [ROW_W-1:0] row,
		input logic [COL_W-1:0] col
	);
		return ADDR_W'(ADDR_W'(row) * ADDR_W'(STRIDE) + ADDR_W'(col));
	endfunction

	function automatic logic [MAG_W-1:0] magnitude(input logic signed [15:0] v);
		logic [MAG_W-1:0] u;
		u = MAG_W'(v);
		return u[MAG_W-1] ? MAG_W'(~u + 1'b1) : u;
	endfunction

	// cursor inside the store, and the character a put writes
	assign row_live = cur_row_q < ROW_W'(ROWS);
	assign put_char = (item_q.char_code < CH_SPACE || item_q.char_code > CH_LAST_PRINT) ?
		CH_SPACE : item_q.char_code;

	// result register takes a new beat when empty or draining this cycle
	assign rsp_load = (state_q == ST_RESP) && (!rsp_valid_q || rsp_ready);

	tcsb_ram #(
		.WIDTH(8),
		.DEPTH(CELLS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	tcsb_modred u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mod_start),
		.col_mag (magnitude(item_q.target_col)),
		.row_mag (magnitude(item_q.target_row)),
		.col_rem (col_rem),
		.row_rem (row_rem),
		.done    (mod_done)
	);

	// RAM port control per state; the copy write lands in the cycle after its read
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = CH_NUL;
		ram_raddr = '0;
		mod_start = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
			end
			ST_EXEC: begin
				unique case (item_q.operation)
					OP_PUT: begin
						ram_we    = row_live;
						ram_waddr = cell_addr(cur_row_q, cur_col_q);
						ram_wdata = (item_q.char_code == CH_NEWLINE) ? CH_NUL : put_char;
					end
					OP_TERM: begin
						ram_we    = row_live;
						ram_waddr = cell_addr(cur_row_q, cur_col_q);
					end
					OP_MOVE: begin
						mod_start = 1'b1;
					end
					OP_READ: begin
						ram_raddr = cell_addr(ROW_W'(item_q.read_row), COL_W'(item_q.read_col));
					end
					default: begin
					end
				endcase
			end
			ST_PUT_TERM: begin
				ram_we    = 1'b1;
				ram_waddr = cell_addr(cur_row_q, COL_W'(COLS));
			end
			ST_SCROLL_CP: begin
				ram_raddr = cell_addr(ROW_W'(sc_row_q + 1'b1), sc_col_q);
			end
			ST_SCROLL_FILL: begin
				ram_we    = 1'b1;
				ram_waddr = cell_addr(ROW_W'(ROWS - 1), sc_col_q);
				ram_wdata = (sc_col_q == COL_W'(COLS)) ? CH_NUL : CH_SPACE;
			end
			default: begin
			end
		endcase
		if (cp_valid_s1) begin
			ram_we    = 1'b1;
			ram_waddr = cp_addr_s1;
			ram_wdata = cp_term_s1 ? CH_NUL : ram_rdata;
		end
	end

	// sequencer: state, cursor, scroll counters and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			cur_col_q   <= '0;
			cur_row_q   <= '0;
			cp_valid_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			cp_valid_s1 <= state_q == ST_SCROLL_CP;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(CELLS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_valid) begin
						item_q     <= req;
						cell_q     <= CH_NUL;
						scrolled_q <= 1'b0;
						state_q    <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					unique case (item_q.operation)
						OP_PUT: begin
							if (!row_live) begin
								sc_row_q <= '0;
								sc_col_q <= '0;
								state_q  <= ST_SCROLL_CP;
							end else if (item_q.char_code == CH_NEWLINE) begin
								cur_row_q <= cur_row_q + 1'b1;
								cur_col_q <= '0;
								state_q   <= ST_RESP;
							end else if (cur_col_q < COL_W'(COLS - 1)) begin
								cur_col_q <= cur_col_q + 1'b1;
								state_q   <= ST_RESP;
							end else begin
								state_q <= ST_PUT_TERM;
							end
						end
						OP_TERM: begin
							state_q <= ST_RESP;
						end
						OP_MOVE: begin
							state_q <= ST_MOVE;
						end
						OP_READ: begin
							rd_inrange_q <= (ROW_W'(item_q.read_row) < ROW_W'(ROWS)) &&
								({1'b0, item_q.read_col} < 7'(STRIDE));
							state_q <= ST_READ;
						end
						default: begin
						end
					endcase
				end
				ST_PUT_TERM: begin
					cur_row_q <= cur_row_q + 1'b1;
					cur_col_q <= '0;
					state_q   <= ST_RESP;
				end
				ST_SCROLL_CP: begin
					cp_addr_s1  <= cell_addr(sc_row_q, sc_col_q);
					cp_term_s1  <= sc_col_q == COL_W'(COLS);
					if (sc_col_q == COL_W'(COLS)) begin
						sc_col_q <= '0;
						if (sc_row_q == ROW_W'(ROWS - 2)) begin
							state_q <= ST_SCROLL_DRAIN;
						end else begin
							sc_row_q <= sc_row_q + 1'b1;
						end
					end else begin
						sc_col_q <= sc_col_q + 1'b1;
					end
				end
				ST_SCROLL_DRAIN: begin
					sc_col_q <= '0;
					state_q  <= ST_SCROLL_FILL;
				end
				ST_SCROLL_FILL: begin
					if (sc_col_q == COL_W'(COLS)) begin
						cur_row_q  <= ROW_W'(ROWS - 1);
						cur_col_q  <= '0;
						scrolled_q <= 1'b1;
						state_q    <= ST_EXEC;
					end else begin
						sc_col_q <= sc_col_q + 1'b1;
					end
				end
				ST_MOVE: begin
					if (mod_done) begin
						cur_col_q <= COL_W'(col_rem);
						cur_row_q <= ROW_W'(row_rem);
						state_q   <= ST_RESP;
					end
				end
				ST_READ: begin
					cell_q  <= rd_inrange_q ? ram_rdata : CH_NUL;
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (rsp_load) begin
						rsp_q.cell_char     <= cell_q;
						rsp_q.cursor_col    <= 6'(cur_col_q);
						rsp_q.cursor_row    <= 5'(cur_row_q);
						rsp_q.scrolled      <= scrolled_q;
						state_q             <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign req_ready = state_q == ST_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef ASSERT_OFF
	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cur_col_q < COL_W'(COLS))
		else $error("cursor column reached the terminator column");

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cur_row_q <= ROW_W'(ROWS))
		else $error("cursor row beyond scroll-pending row");

	a_copy_in_scroll: assert property (@(posedge clk) disable iff (!arst_n)
		cp_valid_s1 |-> (state_q == ST_SCROLL_CP || state_q == ST_SCROLL_DRAIN))
		else $error("scroll copy write outside the scroll sweep");

	a_move_done: assert property (@(posedge clk) disable iff (!arst_n)
		mod_done |-> state_q == ST_MOVE)
		else $error("remainder unit finished outside a move");
`endif

endmodule

### dv/testbench.sv
// Self-checking bench for text_console_scroll_buffer: directed table, then random console traffic.
// Depends on tcsb_pkg and the design files; responses are checked against the table or a shadow console.
`timescale 1ns / 1ps

module testbench
	import tcsb_pkg::*;
();

	localparam int N_RANDOM   = 1425;
	localparam int SCROLL_CAP = 50;
	localparam int N_PLAN     = 25;

	// Directed row: request fields, then the response where it is obvious
	typedef struct packed {
		op_t         op;
		logic [7:0]  ch;
		logic [15:0] tcol;
		logic [15:0] trow;
		logic [3:0]  rrow;
		logic [5:0]  rcol;
		logic        known;
		logic [7:0]  ccell;
		logic [5:0]  ccol;
		logic [4:0]  crow;
		logic        scr;
	} plan_row_t;

	localparam plan_row_t PLAN [N_PLAN] = '{
		// empty store after reset, both corners
		'{OP_READ, 8'h00, 16'h0000, 16'h0000, 4'd0,  6'd0,  1'b1, 8'h00, 6'd0,  5'd0,  1'b0},
		'{OP_READ, 8'h00, 16'h0000, 16'h0000, 4'd15, 6'd63, 1'b1, 8'h00, 6'd0,  5'd0,  1'b0},
		// move extremes: most negative and most positive targets
		'{OP_MOVE, 8'h00, 16'h8000, 16'h8000, 4'd0,  6'd0,  1'b1, 8'h00, 6'd8,  5'd0,  1'b0},
		'{OP_MOVE, 8'h00, 16'h7FFF, 16'h7FFF, 4'd0,  6'd0,  1'b1, 8'h00, 6'd7,  5'd15, 1'b0},
		// wrap off the last cell of the last line leaves a scroll pending
		'{OP_MOVE, 8'h00, 16'd62,   16'd15,   4'd0,  6'd0,  1'b1, 8'h00, 6'd62, 5'd15, 1'b0},
		'{OP_PUT,  8'h41, 16'h0000, 16'h0000, 4'd0,  6'd0,  1'b1, 8'h00, 6'd0,  5'd16, 1'b0},
		'{OP_TERM, 8'h00, 16'h0000, 16'h0000, 4'd0,  6'd0,  1'b1, 8'h00, 6'd0,  5'd16, 1'b0},
		'{OP_READ, 8'h00, 16'h0000, 16'h0000, 4'd15, 6'd62, 1'b1, 8'h41, 6'd0,  5'd16, 1'b0},
		'{OP_READ, 8'h00, 16'h0000, 16'h0000, 4'd15, 6'd63, 1'b1, 8'h00, 6'd0,  5'd16, 1'b0},
		// put below the last line scrolls; old last line moves up, new one is blank
		'{OP_PUT,  8'h7E, 16'h0000, 16'h0000, 4'd0,  6'd0,  1'b1, 8'h00, 6'd1,  5'd15, 1'b1},
		'{OP_READ, 8'h00, 16'h0000, 16'h0000, 4'd14, 6'd62, 1'b1, 8'h41, 6'd1,  5'd15, 1'b0},
		'{OP_READ, 8'h00, 16'h0000, 16'h0000, 4'd15, 6'd1,  1'b1, 8'h20, 6'd1,  5'd15, 1'b0},
		// non-printable bytes on both sides of the printable range, then its lowest code
		'{OP_PUT,  8'h1F, 16'h0000, 16'h0000, 4'd0,  6'd0,  1'b1, 8'h00, 6'd2,  5'd15, 1'b0},
		'{OP_PUT,  8'h80, 16'h0000, 16'h0000, 4'd0,  6'd0,  1'b1, 8'h00, 6'd3,  5'd15, 1'b0},
		'{OP_PUT,  8'hFF, 16'h0000, 16'h0000, 4'd0,  6'd0,  1'b1, 8'h00, 6'd4,  5'd15, 1'b0},
		'{OP_PUT,  8'h20, 16'h0000, 16'h0000, 4'd0,  6'd0,  1'b1, 8'h00, 6'd5,  5'd15, 1'b0},
		// newline on the last line, then a newline that scrolls first
		'{OP_PUT,  8'h0A, 16'h0000, 16'h0000, 4'd0,  6'd0,  1'b1, 8'h00, 6'd0,  5'd16, 1'b0},
		'{OP_READ, 8'h00, 16'h0000, 16'h0000, 4'd15, 6'd5,  1'b1, 8'h00, 6'd0,  5'd16, 1'b0},
		'{OP_PUT,  8'h0A, 16'h0000, 16'h0000, 4'd0,  6'd0,  1'b1, 8'h00, 6'd0,  5'd16, 1'b1},
		// home, NUL byte, terminate inside the store
		'{OP_MOVE, 8'h00, 16'h0000, 16'h0000, 4'd0,  6'd0,  1'b1, 8'h00, 6'd0,  5'd0,  1'b0},
		'{OP_PUT,  8'h00, 16'h0000, 16'h0000, 4'd0,  6'd0,  1'b0, 8'h00, 6'd0,  5'd0,  1'b0},
		'{OP_TERM, 8'hFF, 16'hFFFF, 16'hFFFF, 4'd15, 6'd63, 1'b0, 8'h00, 6'd0,  5'd0,  1'b0},
		'{OP_READ, 8'h00, 16'h0000, 16'h0000, 4'd0,  6'd0,  1'b1, 8'h20, 6'd1,  5'd0,  1'b0},
		// small negative targets
		'{OP_MOVE, 8'h00, 16'hFFFF, 16'hFFEF, 4'd0,  6'd0,  1'b1, 8'h00, 6'd1,  5'd1,  1'b0},
		'{OP_READ, 8'h00, 16'h0000, 16'h0000, 4'd0,  6'd1,  1'b1, 8'h00, 6'd1,  5'd1,  1'b0}
	};

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_RANDOM,
		RX_NOTCH,
		RX_SLOW
	} rx_mode_t;

	logic clk;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	// Shadow console state
	logic [7:0] shadow_cells [CELLS];
	int         shadow_col;
	int         shadow_row;

	rsp_t rsp_due [$];
	int   mismatches = 0;
	int   rsp_seen   = 0;
	int   burst_left = 0;
	int   issued     = 0;
	int   scrolls    = 0;
	int   op_count [4] = '{0, 0, 0, 0};

	rx_mode_t    rx_mode   = RX_OPEN;
	int unsigned rx_left   = 0;
	logic [3:0]  rx_tick   = '0;

	text_console_scroll_buffer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("text_console_scroll_buffer: mismatch");
		$finish;
	end

	// Magnitude of a 16-bit two's complement value; 0x8000 gives 32768
	function automatic int magnitude16(input logic [15:0] raw);
		int v;
		v = raw;
		return raw[15] ? 32'h10000 - v : v;
	endfunction

	// Advance the shadow console by one request beat, return its response
	function automatic rsp_t console_step(input req_t r);
		rsp_t       res;
		logic [7:0] ch;
		res = '0;
		ch  = r.char_code;
		case (r.operation)
			OP_PUT: begin
				// scroll first when the cursor sits below the last line
				if (shadow_row >= ROWS) begin
					for (int j = 0; j < ROWS - 1; j++) begin
						for (int k = 0; k < COLS; k++)
							shadow_cells[j*STRIDE + k] = shadow_cells[(j+1)*STRIDE + k];
						shadow_cells[j*STRIDE + COLS] = CH_NUL;
					end
					for (int k = 0; k < COLS; k++)
						shadow_cells[(ROWS-1)*STRIDE + k] = CH_SPACE;
					shadow_cells[(ROWS-1)*STRIDE + COLS] = CH_NUL;
					shadow_row   = ROWS - 1;
					shadow_col   = 0;
					res.scrolled = 1'b1;
				end
				if (ch == CH_NEWLINE) begin
					shadow_cells[shadow_row*STRIDE + shadow_col] = CH_NUL;
					shadow_row++;
					shadow_col = 0;
				end else begin
					if (ch < CH_SPACE || ch > CH_LAST_PRINT)
						ch = CH_SPACE;
					shadow_cells[shadow_row*STRIDE + shadow_col] = ch;
					if (shadow_col < COLS - 1) begin
						shadow_col++;
					end else begin
						// wrap: close the line just left
						shadow_cells[shadow_row*STRIDE + COLS] = CH_NUL;
						shadow_row++;
						shadow_col = 0;
					end
				end
			end
			OP_TERM: begin
				if (shadow_row < ROWS)
					shadow_cells[shadow_row*STRIDE + shadow_col] = CH_NUL;
			end
			OP_MOVE: begin
				shadow_col = magnitude16(r.target_col) % COLS;
				shadow_row = magnitude16(r.target_row) % ROWS;
			end
			default: begin
				if (r.read_row < ROWS && r.read_col < STRIDE)
					res.cell_char = shadow_cells[r.read_row*STRIDE + r.read_col];
			end
		endcase
		res.cursor_col = 6'(shadow_col);
		res.cursor_row = 5'(shadow_row);
		return res;
	endfunction

	// Every field random over its full range
	function automatic req_t any_beat();
		req_t r;
		r.operation  = op_t'($urandom_range(0, 3));
		r.char_code  = 8'($urandom);
		r.target_col = 16'($urandom);
		r.target_row = 16'($urandom);
		r.read_row   = 4'($urandom);
		r.read_col   = 6'($urandom);
		return r;
	endfunction

	// Drive one beat in bursts with random gaps; predict once it is accepted
	task automatic send_beat(input req_t item, input logic known, input rsp_t typed);
		int   gap;
		rsp_t want;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		req       <= item;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (!(req_valid && req_ready));
		want = console_step(item);
		rsp_due.push_back(known ? typed : want);
		op_count[item.operation]++;
		if (want.scrolled)
			scrolls++;
	endtask

	// Random beat; a put that would scroll past the budget becomes a move
	task automatic issue(input req_t r);
		if (r.operation == OP_PUT && shadow_row >= ROWS && scrolls >= SCROLL_CAP)
			r.operation = OP_MOVE;
		send_beat(r, 1'b0, '0);
		issued++;
	endtask

	// Hold the sender off until every response is back
	task automatic drain();
		req_valid <= 1'b0;
		while (rsp_due.size() != 0)
			@(posedge clk);
	endtask

	// Receiver stalls: modes of random length, each with its own pattern
	always @(posedge clk) begin
		rx_tick <= rx_tick + 4'd1;
		if (rx_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
			rx_left <= $urandom_range(40, 300);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			RX_OPEN:   rsp_ready <= 1'b1;
			RX_RANDOM: rsp_ready <= ($urandom_range(0, 3) != 0);
			RX_NOTCH:  rsp_ready <= (rx_tick[2:0] != 3'd0) && (rx_tick[2:0] != 3'd5);
			default:   rsp_ready <= rx_tick[3];
		endcase
	end

	// Response check against the oldest expectation
	always @(posedge clk) begin : rsp_check
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			rsp_seen++;
			if (rsp_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("response %0d arrived with nothing expected: %p", rsp_seen, rsp);
			end else begin
				want = rsp_due.pop_front();
				if (rsp.cell_char !== want.cell_char || rsp.cursor_col !== want.cursor_col ||
				    rsp.cursor_row !== want.cursor_row || rsp.scrolled !== want.scrolled) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"response %0d (exp/got): cell %h/%h col %0d/%0d ",
							"row %0d/%0d scrolled %0d/%0d"}, rsp_seen,
							want.cell_char, rsp.cell_char, want.cursor_col, rsp.cursor_col,
							want.cursor_row, rsp.cursor_row, want.scrolled, rsp.scrolled);
				end
			end
		end
	end

	// Stimulus
	initial begin : stimulus
		req_t r;
		rsp_t typed;
		int   pick;
		int   len;
		int   t;
		int   next_drain;
		foreach (shadow_cells[i])
			shadow_cells[i] = CH_NUL;
		shadow_col = 0;
		shadow_row = 0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed table
		for (int i = 0; i < N_PLAN; i++) begin
			r.operation  = PLAN[i].op;
			r.char_code  = PLAN[i].ch;
			r.target_col = PLAN[i].tcol;
			r.target_row = PLAN[i].trow;
			r.read_row   = PLAN[i].rrow;
			r.read_col   = PLAN[i].rcol;
			typed = '{PLAN[i].ccell, PLAN[i].ccol, PLAN[i].crow, PLAN[i].scr};
			send_beat(r, PLAN[i].known, typed);
		end
		drain();

		// random console traffic: mostly lines of text with read-back
		next_drain = $urandom_range(200, 400);
		while (issued < N_RANDOM) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				if ($urandom_range(0, 2) == 0) begin
					r = any_beat();
					r.operation = OP_MOVE;
					t = $urandom_range(0, 80);
					r.target_col = 16'($urandom_range(0, 1) ? -t : t);
					t = $urandom_range(0, 20);
					r.target_row = 16'($urandom_range(0, 1) ? -t : t);
					issue(r);
				end
				len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 70) : $urandom_range(1, 12);
				repeat (len) begin
					r = any_beat();
					r.operation = OP_PUT;
					if ($urandom_range(0, 9) != 0)
						r.char_code = 8'($urandom_range(32, 126));
					issue(r);
				end
				// end the line with a newline or a terminate
				r = any_beat();
				r.operation = ($urandom_range(0, 3) == 0) ? OP_TERM : OP_PUT;
				r.char_code = CH_NEWLINE;
				issue(r);
				repeat ($urandom_range(0, 4)) begin
					r = any_beat();
					r.operation = OP_READ;
					if ($urandom_range(0, 1))
						r.read_row = 4'((shadow_row == 0) ? 0 : shadow_row - 1);
					issue(r);
				end
			end else if (pick < 85) begin
				issue(any_beat());
			end else begin
				r = any_beat();
				r.operation = OP_READ;
				issue(r);
			end
			if (issued >= next_drain) begin
				drain();
				next_drain += $urandom_range(200, 400);
			end
		end

		// wind down
		req_valid <= 1'b0;
		while (rsp_due.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("%0d beats: %0d puts, %0d terminates, %0d moves, %0d reads",
			N_PLAN + issued, op_count[OP_PUT], op_count[OP_TERM],
			op_count[OP_MOVE], op_count[OP_READ]);
		$display("%0d scrolls, %0d responses checked, %0d mismatches",
			scrolls, rsp_seen, mismatches);
		if (mismatches == 0)
			$display("text_console_scroll_buffer: match");
		else
			$display("text_console_scroll_buffer: mismatch");
		$finish;
	end

endmodule
